>>> src/assert_macros.svh
// assertion macros included by the word set top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked under reset guard
`define LPWS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define LPWS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPWS_ASSERT(label, clk, rst, prop, msg)
`define LPWS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> src/lpws_pkg.sv
// types, codes and helpers of the linear probing word set
package lpws_pkg;

   localparam int LOG2_SLOTS        = 10;
   localparam int SLOT_COUNT        = 1 << LOG2_SLOTS;
   localparam int MAX_WORD_BYTES    = 22;
   localparam int MIN_CAPACITY_LOG2 = 4;
   localparam int TEXT_BYTES        = 22;
   localparam int TEXT_BITS         = TEXT_BYTES * 8;
   localparam int COUNT_WIDTH       = 11;
   localparam int SLOT_INDEX_WIDTH  = 10;
   localparam int CAP_LOG2_WIDTH    = 4;
   localparam int CSR_INDEX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH    = 11;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAPACITY_LOG2 = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOAD_LIMIT    = 2'd1;

   localparam logic [CAP_LOG2_WIDTH-1:0] CAPACITY_LOG2_RESET = 4'd10;
   localparam logic [COUNT_WIDTH-1:0]    LOAD_LIMIT_RESET    = 11'd768;
   localparam logic [COUNT_WIDTH-1:0]    COUNT_MAX           = '1;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_CLEAR  = 1'b1;

   localparam logic [2:0] STATUS_INSERTED  = 3'd0;
   localparam logic [2:0] STATUS_DUPLICATE = 3'd1;
   localparam logic [2:0] STATUS_FULL      = 3'd2;
   localparam logic [2:0] STATUS_TOO_LONG  = 3'd3;
   localparam logic [2:0] STATUS_CLEARED   = 3'd4;

   typedef struct packed {
      logic        mode;
      logic [63:0] key_hash;
      logic [4:0]  key_length;
      logic [63:0] text_bytes_low;
      logic [63:0] text_bytes_mid;
      logic [47:0] text_bytes_high;
   } req_type;

   typedef struct packed {
      logic [2:0]                  status;
      logic [SLOT_INDEX_WIDTH-1:0] slot_index;
      logic [COUNT_WIDTH-1:0]      entry_count;
      logic                        limit_reached;
   } rsp_type;

   // one table slot as kept in the ram
   typedef struct packed {
      logic                 valid;
      logic [63:0]          key_hash;
      logic [4:0]           key_length;
      logic [TEXT_BITS-1:0] text;
   } entry_type;

   localparam int ENTRY_WIDTH = $bits(entry_type);

   typedef struct packed {
      logic is_free;
      logic is_match;
   } probe_result_type;

   // zero the bytes at and past the word length
   function automatic logic [TEXT_BITS-1:0] keep_text(input logic [TEXT_BITS-1:0] text,
                                                      input logic [4:0] len);
      logic [TEXT_BITS-1:0] kept;
      kept = '0;
      for (int i = 0; i < TEXT_BYTES; i++) begin
         if (5'(i) < len) begin
            kept[i*8 +: 8] = text[i*8 +: 8];
         end
      end
      return kept;
   endfunction

endpackage

>>> src/lpws_ram.sv
// generic single write, single read ram with registered read data
module lpws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

>>> src/lpws_slot_cmp.sv
// slot compare unit: tells whether a probed slot is free or holds the key
module lpws_slot_cmp (
   input  lpws_pkg::entry_type        stored,
   input  lpws_pkg::entry_type        key,
   output lpws_pkg::probe_result_type result
);
   import lpws_pkg::*;

   assign result.is_free  = !stored.valid;
   assign result.is_match = stored.valid &&
                            stored.key_hash == key.key_hash &&
                            stored.key_length == key.key_length &&
                            stored.text == key.text;

endmodule

>>> src/linear_probe_word_set_insert.sv
// linear probing word set: probe sequencer, slot ram and csr registers
// a too long word is answered straight from idle; an insert fetches, then probes p slots (1..capacity),
// one slot per cycle through the single ram read port and the slot compare unit.
// clear item writes all 1024 slots (one slot written per cycle), then the result beat.
// after reset the same clearing pass runs with busy high and no beat.
// results go out on a one cycle rsp_valid strobe; the receiver cannot stall.
module linear_probe_word_set_insert (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  lpws_pkg::req_type                     req,
   output logic                                  rsp_valid,
   output lpws_pkg::rsp_type                     rsp,
   input  logic                                  csr_write_enable,
   input  logic [lpws_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [lpws_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);
   import lpws_pkg::*;
`include "assert_macros.svh"

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_CLEAR   = 2'd1;
   localparam logic [1:0] ST_FETCH   = 2'd2;
   localparam logic [1:0] ST_COMPARE = 2'd3;

   logic [1:0]                state_ff, state_in;
   entry_type                 key_ff, key_in;
   logic [LOG2_SLOTS-1:0]     slot_ff, slot_in;
   logic [LOG2_SLOTS-1:0]     probe_count_ff, probe_count_in;
   logic [LOG2_SLOTS-1:0]     index_mask_ff, index_mask_in;
   logic [LOG2_SLOTS-1:0]     sweep_ff, sweep_in;
   logic                      notify_clear_ff, notify_clear_in;
   logic [COUNT_WIDTH-1:0]    count_ff, count_in;
   logic [CAP_LOG2_WIDTH-1:0] capacity_log2_ff, capacity_log2_in;
   logic [COUNT_WIDTH-1:0]    load_limit_ff, load_limit_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic                      accept;
   logic [CAP_LOG2_WIDTH-1:0] cap_log2;
   logic [LOG2_SLOTS-1:0]     next_slot;
   logic                      ram_write_enable;
   logic [LOG2_SLOTS-1:0]     ram_write_address;
   entry_type                 ram_write_data;
   logic [LOG2_SLOTS-1:0]     ram_read_address;
   logic [ENTRY_WIDTH-1:0]    ram_read_data;
   entry_type                 stored;
   probe_result_type          probe;

   assign accept    = start && !busy;
   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign stored    = entry_type'(ram_read_data);
   assign next_slot = (slot_ff + 1'b1) & index_mask_ff;

   always_comb begin
      if (capacity_log2_ff < CAP_LOG2_WIDTH'(MIN_CAPACITY_LOG2)) begin
         cap_log2 = CAP_LOG2_WIDTH'(MIN_CAPACITY_LOG2);
      end else if (capacity_log2_ff > CAP_LOG2_WIDTH'(LOG2_SLOTS)) begin
         cap_log2 = CAP_LOG2_WIDTH'(LOG2_SLOTS);
      end else begin
         cap_log2 = capacity_log2_ff;
      end
   end

   lpws_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (SLOT_COUNT)
   ) slot_ram (
      .clock         (clock),
      .write_enable  (ram_write_enable),
      .write_address (ram_write_address),
      .write_data    (ram_write_data),
      .read_address  (ram_read_address),
      .read_data     (ram_read_data)
   );

   lpws_slot_cmp slot_cmp (
      .stored (stored),
      .key    (key_ff),
      .result (probe)
   );

   always_comb begin
      state_in         = state_ff;
      key_in           = key_ff;
      slot_in          = slot_ff;
      probe_count_in   = probe_count_ff;
      index_mask_in    = index_mask_ff;
      sweep_in         = sweep_ff;
      notify_clear_in  = notify_clear_ff;
      count_in         = count_ff;
      capacity_log2_in = capacity_log2_ff;
      load_limit_in    = load_limit_ff;
      rsp_valid_in     = 1'b0;
      rsp_in           = rsp_ff;
      ram_write_enable  = 1'b0;
      ram_write_address = slot_ff;
      ram_write_data    = key_ff;
      ram_read_address  = slot_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_CAPACITY_LOG2: capacity_log2_in = csr_write_data[CAP_LOG2_WIDTH-1:0];
            CSR_LOAD_LIMIT:    load_limit_in    = csr_write_data[COUNT_WIDTH-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.mode == MODE_CLEAR) begin
                  state_in        = ST_CLEAR;
                  sweep_in        = '0;
                  notify_clear_in = 1'b1;
               end else if (req.key_length > 5'(MAX_WORD_BYTES)) begin
                  rsp_valid_in         = 1'b1;
                  rsp_in.status        = STATUS_TOO_LONG;
                  rsp_in.slot_index    = '0;
                  rsp_in.entry_count   = count_ff;
                  rsp_in.limit_reached = count_ff >= load_limit_ff;
               end else begin
                  key_in.valid      = 1'b1;
                  key_in.key_hash   = req.key_hash;
                  key_in.key_length = req.key_length;
                  key_in.text       = keep_text({req.text_bytes_high, req.text_bytes_mid,
                                                 req.text_bytes_low}, req.key_length);
                  index_mask_in     = ~({LOG2_SLOTS{1'b1}} << cap_log2);
                  slot_in           = req.key_hash[LOG2_SLOTS-1:0] & index_mask_in;
                  probe_count_in    = '0;
                  state_in          = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            // look ahead one slot so a miss moves straight on to the next slot
            ram_read_address = next_slot;
            if (probe.is_free) begin
               ram_write_enable = 1'b1;
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
               rsp_valid_in         = 1'b1;
               rsp_in.status        = STATUS_INSERTED;
               rsp_in.slot_index    = SLOT_INDEX_WIDTH'(slot_ff);
               rsp_in.entry_count   = count_in;
               rsp_in.limit_reached = count_in >= load_limit_ff;
               state_in             = ST_IDLE;
            end else if (probe.is_match) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = STATUS_DUPLICATE;
               rsp_in.slot_index    = SLOT_INDEX_WIDTH'(slot_ff);
               rsp_in.entry_count   = count_ff;
               rsp_in.limit_reached = count_ff >= load_limit_ff;
               state_in             = ST_IDLE;
            end else if (probe_count_ff == index_mask_ff) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = STATUS_FULL;
               rsp_in.slot_index    = '0;
               rsp_in.entry_count   = count_ff;
               rsp_in.limit_reached = count_ff >= load_limit_ff;
               state_in             = ST_IDLE;
            end else begin
               slot_in        = next_slot;
               probe_count_in = probe_count_ff + 1'b1;
            end
         end
         ST_CLEAR: begin
            ram_write_enable  = 1'b1;
            ram_write_address = sweep_ff;
            ram_write_data    = '0;
            sweep_in          = sweep_ff + 1'b1;
            if (sweep_ff == {LOG2_SLOTS{1'b1}}) begin
               count_in = '0;
               state_in = ST_IDLE;
               if (notify_clear_ff) begin
                  rsp_valid_in         = 1'b1;
                  rsp_in.status        = STATUS_CLEARED;
                  rsp_in.slot_index    = '0;
                  rsp_in.entry_count   = '0;
                  rsp_in.limit_reached = load_limit_ff == '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         sweep_ff         <= '0;
         notify_clear_ff  <= 1'b0;
         count_ff         <= '0;
         capacity_log2_ff <= CAPACITY_LOG2_RESET;
         load_limit_ff    <= LOAD_LIMIT_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         sweep_ff         <= sweep_in;
         notify_clear_ff  <= notify_clear_in;
         count_ff         <= count_in;
         capacity_log2_ff <= capacity_log2_in;
         load_limit_ff    <= load_limit_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      key_ff         <= key_in;
      slot_ff        <= slot_in;
      probe_count_ff <= probe_count_in;
      index_mask_ff  <= index_mask_in;
      rsp_ff         <= rsp_in;
   end

   `LPWS_ASSERT(a_rsp_only_when_idle, clock, reset, rsp_valid_ff |-> state_ff == ST_IDLE, "result beat while busy")
   `LPWS_ASSERT(a_clear_starts_sweep, clock, reset, accept && req.mode == MODE_CLEAR |=> state_ff == ST_CLEAR && sweep_ff == '0, "clear item did not start sweep")
   `LPWS_ASSERT(a_insert_counts, clock, reset, rsp_valid_ff && rsp_ff.status == STATUS_INSERTED |-> rsp_ff.entry_count != '0, "insert beat with zero count")
   `LPWS_ASSERT(a_write_in_work, clock, reset, ram_write_enable |-> state_ff == ST_CLEAR || state_ff == ST_COMPARE, "slot write outside probe or sweep")
   `LPWS_ASSERT_ALWAYS(a_reset_sweeps, clock, reset |=> busy && !rsp_valid, "no clearing pass after reset")

endmodule
